>>> hdl/rpn_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the postfix character stream evaluator.
// No dependencies.
package rpn_pkg;

  localparam int WORD_W  = 32;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_UNDERFLOW = 3'd1;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd2;
  localparam logic [2:0] STAT_DIV_ZERO  = 3'd3;
  localparam logic [2:0] STAT_BAD_CHAR  = 3'd4;

  typedef enum logic [1:0] {
    K_DIGIT,
    K_SPACE,
    K_OP,
    K_BAD
  } kind_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_XOR
  } op_t;

  typedef struct packed {
    kind_t      kind;
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

endpackage

>>> hdl/rpn_front.sv
`timescale 1ns / 1ps
// Input side: accepts characters and decodes them into queue commands.
// Depends on rpn_pkg.
module rpn_front import rpn_pkg::*; (
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  input  logic       q_full,
  input  logic       init_busy,
  output logic       push,
  output cmd_t       push_cmd
);

  assign in_stall  = q_full | init_busy;
  assign push      = in_valid & ~in_stall & rst_n;

  always_comb begin
    push_cmd.kind  = K_BAD;
    push_cmd.op    = OP_ADD;
    push_cmd.digit = in_char_code[3:0];
    push_cmd.last  = in_last_char;
    if (in_char_code inside {[CH_ZERO:CH_NINE]}) begin
      push_cmd.kind = K_DIGIT;
    end else begin
      case (in_char_code)
        CH_SPACE: push_cmd.kind = K_SPACE;
        CH_PLUS: begin
          push_cmd.kind = K_OP;
          push_cmd.op   = OP_ADD;
        end
        CH_MINUS: begin
          push_cmd.kind = K_OP;
          push_cmd.op   = OP_SUB;
        end
        CH_STAR: begin
          push_cmd.kind = K_OP;
          push_cmd.op   = OP_MUL;
        end
        CH_SLASH: begin
          push_cmd.kind = K_OP;
          push_cmd.op   = OP_DIV;
        end
        CH_CARET: begin
          push_cmd.kind = K_OP;
          push_cmd.op   = OP_XOR;
        end
        default: push_cmd.kind = K_BAD;
      endcase
    end
  end

endmodule

>>> hdl/rpn_queue.sv
`timescale 1ns / 1ps
// Small command queue between the decode side and the execution side.
// Depends on rpn_pkg.
module rpn_queue import rpn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t              slot_r [Q_DEPTH];
  logic [Q_AW-1:0]   wp_r, wp_nxt;
  logic [Q_AW-1:0]   rp_r, rp_nxt;
  logic [Q_AW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

>>> hdl/rpn_div.sv
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on rpn_pkg.
module rpn_div import rpn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  localparam int CW = $clog2(WORD_W);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] quo_r;
  logic [WORD_W-1:0] dvs_r;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   diff;

  assign rem_sh   = {rem_r, quo_r[WORD_W-1]};
  assign diff     = rem_sh - {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CW'(WORD_W - 1);
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= diff[WORD_W] ? rem_sh[WORD_W-1:0] : diff[WORD_W-1:0];
      quo_r <= {quo_r[WORD_W-2:0], ~diff[WORD_W]};
    end
  end

endmodule

>>> hdl/rpn_back.sv
`timescale 1ns / 1ps
// Execution side: operand stack memory, sequencer, result register.
// Depends on rpn_pkg and rpn_div.
module rpn_back import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               init_busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [AW-1:0] TOP_MAX = AW'(STACK_DEPTH - 1);
  localparam logic [AW:0]   TWO     = (AW+1)'(2);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EXEC  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_CLR   = 8'b0001_0000,
    S_FIN   = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_SWEEP = 8'b1000_0000
  } bstate_t;

  function automatic logic [2:0] first_err(input logic [2:0] cur, input logic [2:0] code);
    return (cur == STAT_OK) ? code : cur;
  endfunction

  logic [WORD_W-1:0] stack_mem_r [STACK_DEPTH];

  bstate_t            state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [AW-1:0]      top_r, top_nxt;
  logic [AW-1:0]      hwm_r, hwm_nxt;
  logic [AW-1:0]      sweep_r, sweep_nxt;
  logic [2:0]         err_r, err_nxt;
  logic               init_r, init_nxt;
  logic               neg_r, neg_nxt;
  logic [WORD_W-1:0]  res_r, res_nxt;
  logic [WORD_W-1:0]  rda_r, rdb_r;
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic [2:0]         out_status_r;

  logic [AW-1:0]      ra, rb, wa;
  logic               we;
  logic [WORD_W-1:0]  wd;
  logic               out_load;
  logic [AW-1:0]      top_m1, top_m2, top_inc;
  logic               top_low;
  logic [WORD_W-1:0]  mag_a, mag_b, digit_val;
  logic               div_start, div_done;
  logic [WORD_W-1:0]  div_q;

  assign top_m1    = top_r - 1'b1;
  assign top_m2    = top_r - AW'(2);
  assign top_inc   = top_r + 1'b1;
  assign top_low   = ({1'b0, top_r} < TWO);
  assign mag_a     = rda_r[WORD_W-1] ? ~rda_r + 1'b1 : rda_r;
  assign mag_b     = rdb_r[WORD_W-1] ? ~rdb_r + 1'b1 : rdb_r;
  assign digit_val = (rda_r << 3) + (rda_r << 1) + {{(WORD_W-4){1'b0}}, cmd_r.digit};

  assign init_busy  = init_r;
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    top_nxt   = top_r;
    hwm_nxt   = hwm_r;
    sweep_nxt = sweep_r;
    err_nxt   = err_r;
    init_nxt  = init_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    ra        = '0;
    rb        = '0;
    we        = 1'b0;
    wa        = top_r;
    wd        = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          case (q_cmd.kind)
            K_DIGIT: begin
              ra        = top_r;
              state_nxt = S_EXEC;
            end
            K_SPACE: begin
              if (top_r == TOP_MAX) begin
                err_nxt = first_err(err_r, STAT_OVERFLOW);
              end else begin
                top_nxt = top_inc;
                if (top_inc > hwm_r) begin
                  hwm_nxt = top_inc;
                end
              end
              state_nxt = q_cmd.last ? S_FIN : S_IDLE;
            end
            K_OP: begin
              if (top_low) begin
                err_nxt   = first_err(err_r, STAT_UNDERFLOW);
                state_nxt = q_cmd.last ? S_FIN : S_IDLE;
              end else begin
                ra        = top_m2;
                rb        = top_m1;
                state_nxt = S_EXEC;
              end
            end
            default: begin
              err_nxt   = first_err(err_r, STAT_BAD_CHAR);
              state_nxt = q_cmd.last ? S_FIN : S_IDLE;
            end
          endcase
        end
      end
      S_EXEC: begin
        wa = top_m2;
        if (cmd_r.kind == K_DIGIT) begin
          we        = 1'b1;
          wa        = top_r;
          wd        = digit_val;
          state_nxt = cmd_r.last ? S_FIN : S_IDLE;
        end else begin
          case (cmd_r.op)
            OP_ADD: begin
              we        = 1'b1;
              wd        = rda_r + rdb_r;
              state_nxt = S_CLR;
            end
            OP_SUB: begin
              we        = 1'b1;
              wd        = rda_r - rdb_r;
              state_nxt = S_CLR;
            end
            OP_XOR: begin
              we        = 1'b1;
              wd        = rda_r ^ rdb_r;
              state_nxt = S_CLR;
            end
            OP_MUL: begin
              res_nxt   = rda_r * rdb_r;
              state_nxt = S_MUL;
            end
            OP_DIV: begin
              if (rdb_r == '0) begin
                err_nxt   = first_err(err_r, STAT_DIV_ZERO);
                state_nxt = cmd_r.last ? S_FIN : S_IDLE;
              end else begin
                div_start = 1'b1;
                neg_nxt   = rda_r[WORD_W-1] ^ rdb_r[WORD_W-1];
                state_nxt = S_DIV;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        we        = 1'b1;
        wa        = top_m2;
        wd        = res_r;
        state_nxt = S_CLR;
      end
      S_DIV: begin
        if (div_done) begin
          we        = 1'b1;
          wa        = top_m2;
          wd        = neg_r ? ~div_q + 1'b1 : div_q;
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        we        = 1'b1;
        wa        = top_m1;
        top_nxt   = top_m2;
        state_nxt = cmd_r.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          top_nxt   = '0;
          err_nxt   = STAT_OK;
          sweep_nxt = '0;
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        we = 1'b1;
        wa = sweep_r;
        if (sweep_r == hwm_r) begin
          hwm_nxt   = '0;
          init_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      top_r       <= '0;
      hwm_r       <= TOP_MAX;
      sweep_r     <= '0;
      err_r       <= STAT_OK;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      hwm_r       <= hwm_nxt;
      sweep_r     <= sweep_nxt;
      err_r       <= err_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_load | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_value_r  <= $signed(rda_r);
      out_status_r <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem_r[wa] <= wd;
    end
    rda_r <= stack_mem_r[ra];
    rdb_r <= stack_mem_r[rb];
  end

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result word raised outside the output step");

  a_clr_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !top_low)
    else $error("operator retired with fewer than two slots");

  a_top_hwm: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= hwm_r)
    else $error("pointer above high-water mark, sweep would miss slots");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != STAT_OK) && (state_r != S_OUT) |=> (err_r == $past(err_r)))
    else $error("error code changed before the expression ended");

endmodule

>>> hdl/rpn_char_stream_evaluator.sv
`timescale 1ns / 1ps
// Postfix integer expression evaluator, one ASCII character per input word.
// Usage:
//   Input channel in_valid/in_stall carries in_char_code and in_last_char.
//   Output channel out_valid/out_stall carries out_value and out_status, one
//   word per expression, after the character flagged last.
//   A decoder feeds a two-entry command queue; an execution sequencer works
//   on a stack memory with two registered read ports, one write port.
// Sequencer per character: S_IDLE, then S_EXEC for a digit or operator; an
//   applied operator ends in S_CLR (* via S_MUL, / via 32-step bit-serial S_DIV).
// End of expression: S_FIN and S_OUT fetch the bottom slot into the output
//   register, then a sweep clears slots up to the highest pointer reached.
//   A last digit goes through the queue, S_IDLE, S_EXEC, S_FIN and S_OUT
//   before it appears at out_valid.
// Reset (rst_n low, synchronous) clears control state, then all STACK_DEPTH
//   stack slots are swept with in_stall high.
// A stalled output holds its word; the queue keeps taking input until full.
// Depends on rpn_pkg, rpn_front, rpn_queue, rpn_back.
module rpn_char_stream_evaluator import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_head;
  logic init_busy;

  rpn_front u_front (
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .q_full       (q_full),
    .init_busy    (init_busy),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  rpn_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  rpn_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_head),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

>>> sim/rpn_checker.sv
`timescale 1ns / 1ps
// Checker for the postfix evaluator: tracks accepted characters, predicts the
// word at each expression end and compares it with the output channel.
// Depends on rpn_pkg.
module rpn_checker import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_value,
  input  logic [2:0]         out_status,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
  } answer_t;

  logic [31:0] slots [STACK_DEPTH];
  int          sp;
  logic [2:0]  err;
  int          fails;
  answer_t     answers_q[$];

  task automatic clear_stack();
    for (int i = 0; i < STACK_DEPTH; i++) slots[i] = '0;
    sp  = 0;
    err = STAT_OK;
  endtask

  function automatic void note_error(logic [2:0] code);
    if (err == STAT_OK) err = code;
  endfunction

  function automatic logic [31:0] quot_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  task automatic eval_char(input logic [7:0] c);
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      slots[sp] = slots[sp] * 32'd10 + {28'd0, c[3:0]};
      return;
    end
    if (c == CH_SPACE) begin
      if (sp + 1 >= STACK_DEPTH) note_error(STAT_OVERFLOW);
      else sp++;
      return;
    end
    case (c)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      CH_CARET: op = OP_XOR;
      default: begin
        note_error(STAT_BAD_CHAR);
        return;
      end
    endcase
    if (sp < 2) begin
      note_error(STAT_UNDERFLOW);
      return;
    end
    a = slots[sp - 2];
    b = slots[sp - 1];
    case (op)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      OP_DIV: begin
        if (b == '0) begin
          note_error(STAT_DIV_ZERO);
          return;
        end
        r = quot_trunc(a, b);
      end
      default: r = a ^ b;
    endcase
    slots[sp - 2] = r;
    slots[sp - 1] = '0;
    sp = sp - 2;
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      clear_stack();
      answers_q.delete();
      fails = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected word, expected none, actual value %0d status %0d",
                   $time, out_value, out_status);
        end else begin
          want = answers_q.pop_front();
          if (out_value !== want.value) begin
            fails++;
            $display("%0t: value mismatch, expected %0d, actual %0d",
                     $time, $signed(want.value), out_value);
          end
          if (out_status !== want.status) begin
            fails++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        eval_char(in_char_code);
        if (in_last_char) begin
          answers_q.push_back('{value: slots[0], status: err});
          clear_stack();
        end
      end
    end
    mismatches  <= fails;
    outstanding <= answers_q.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for the postfix evaluator: clock, reset, character stimulus,
// output back-pressure and the verdict. Depends on rpn_pkg, rpn_checker, RTL.
module tb import rpn_pkg::*; ();

  localparam int STACK_DEPTH = 32;
  localparam int WORD_TARGET = 1700;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_char_code;
  logic               in_last_char;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_value;
  logic [2:0]         out_status;
  int                 mismatches;
  int                 outstanding;

  logic [7:0] expr_q[$];
  bit         in_steady;
  bit         out_steady;
  int         words_sent;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rpn_char_stream_evaluator #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_char_code(in_char_code), .in_last_char(in_last_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_status(out_status)
  );

  rpn_checker #(.STACK_DEPTH(STACK_DEPTH)) u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_char_code(in_char_code), .in_last_char(in_last_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_status(out_status),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  task automatic send_word(input logic [7:0] c, input logic last);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_expr(input bit counted);
    in_steady = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < expr_q.size(); i++)
      send_word(expr_q[i], i == expr_q.size() - 1);
    if (counted) words_sent += expr_q.size();
    expr_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
  endtask

  task automatic add_number(input int max_len);
    int len;
    len = $urandom_range(1, max_len);
    repeat (len) expr_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic add_op();
    case ($urandom_range(0, 4))
      0: expr_q.push_back(CH_PLUS);
      1: expr_q.push_back(CH_MINUS);
      2: expr_q.push_back(CH_STAR);
      3: expr_q.push_back(CH_SLASH);
      default: expr_q.push_back(CH_CARET);
    endcase
  endtask

  // well-formed: tokens joined by single spaces, operators only with two values
  task automatic add_formula(input int steps, input int max_depth);
    int depth;
    depth = 1;
    add_number(($urandom_range(0, 7) == 0) ? 12 : 3);
    repeat (steps) begin
      expr_q.push_back(CH_SPACE);
      if (depth >= 2 && (depth >= max_depth || $urandom_range(0, 1))) begin
        add_op();
        depth--;
      end else begin
        add_number(($urandom_range(0, 7) == 0) ? 12 : 3);
        depth++;
      end
    end
  endtask

  // pushes up to and past the stack top
  task automatic add_tower();
    int n;
    n = $urandom_range(28, 34);
    add_number(1);
    repeat (n - 1) begin
      expr_q.push_back(CH_SPACE);
      add_number(1);
    end
    repeat ($urandom_range(0, n)) begin
      expr_q.push_back(CH_SPACE);
      add_op();
    end
  endtask

  initial begin
    int pick;
    int idx;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = '0;
    in_last_char = 1'b0;
    words_sent   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    expr_q.push_back(8'h00);
    send_expr(1'b1);
    expr_q.push_back(8'hFF);
    send_expr(1'b1);
    expr_q.push_back(CH_PLUS);
    send_expr(1'b1);
    add_text("5 0 /");
    send_expr(1'b1);
    add_text("7 2 ^ 3 /");
    send_expr(1'b1);
    add_text("9 4 - 2 * 1 +");
    send_expr(1'b1);

    while (words_sent < WORD_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        add_formula($urandom_range(0, 14), $urandom_range(2, 8));
        send_expr(1'b1);
      end else if (pick < 74) begin
        add_tower();
        send_expr(1'b1);
      end else if (pick < 78) begin
        // most negative value over minus one
        add_text("2147483648 0 1 - /");
        send_expr(1'b1);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 6)) expr_q.push_back(8'($urandom_range(0, 255)));
        send_expr(1'b0);
      end else begin
        add_formula($urandom_range(1, 10), $urandom_range(2, 6));
        if ($urandom_range(0, 1)) begin
          idx = $urandom_range(0, expr_q.size() - 1);
          expr_q[idx] = 8'($urandom_range(0, 255));
        end else begin
          expr_q.insert(0, CH_SPACE);
          expr_q.insert(0, CH_MINUS);
        end
        send_expr(1'b1);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    out_stall  = 1'b0;
    out_steady = 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) out_steady = !out_steady;
      repeat (out_steady ? 0 : $urandom_range(0, 3)) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
